// File: rtl/core/integer_literal_parser_macros.svh
// Assertion macros for the integer literal parser checker.
// Relies on clk_i and rst_ni being visible where a macro is used.
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ILP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ILP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ilp_pkg.sv
// Shared types, character codes and digit decode for the integer literal parser.
// No dependencies; every module but ilp_checker references it by scoped names.
package ilp_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_e;

  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_A_LO       = 8'h61;
  localparam logic [7:0] CHAR_F_LO       = 8'h66;
  localparam logic [7:0] CHAR_A_UP       = 8'h41;
  localparam logic [7:0] CHAR_F_UP       = 8'h46;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_X_LO       = 8'h78;
  localparam logic [7:0] CHAR_X_UP       = 8'h58;
  localparam logic [7:0] CHAR_O_LO       = 8'h6F;
  localparam logic [7:0] CHAR_O_UP       = 8'h4F;
  localparam logic [7:0] CHAR_B_LO       = 8'h62;
  localparam logic [7:0] CHAR_B_UP       = 8'h42;

  // Digit value returned for a non-digit character
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } in_req_t;

  typedef struct packed {
    logic fire;
    logic is_valid;
  } res_t;

  // Decode a character into its digit value, or DIGIT_NONE
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = 5'(c - CHAR_ZERO);
    end else if (c >= CHAR_A_LO && c <= CHAR_F_LO) begin
      d = 5'(c - CHAR_A_LO + 8'd10);
    end else if (c >= CHAR_A_UP && c <= CHAR_F_UP) begin
      d = 5'(c - CHAR_A_UP + 8'd10);
    end
    return d;
  endfunction

  // Check that a digit value lies below the base of a radix
  function automatic logic digit_fits(input logic [4:0] d, input radix_e r);
    logic ok;
    unique case (r)
      RADIX_DEC: ok = (d < 5'd10);
      RADIX_HEX: ok = (d < 5'd16);
      RADIX_OCT: ok = (d < 5'd8);
      RADIX_BIN: ok = (d < 5'd2);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/core/ilp_in_reg.sv
// Input register stage of the integer literal parser.
// Depends on ilp_pkg for the request types.
module ilp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     char_code_i,
  input  logic           final_char_i,
  input  logic           advance_i,
  output logic           in_stall_o,
  output ilp_pkg::in_req_t req_o
);

  logic            valid_q, valid_d;
  ilp_pkg::item_t  item_q, item_d;
  logic            load;

  // Take a new request when the register is empty or being drained
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        item_d.char_code  = char_code_i;
        item_d.final_char = final_char_i;
      end
    end
  end

  // Clear the valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign req_o.valid = valid_q;
  assign req_o.item  = item_q;

endmodule

// File: rtl/core/ilp_step.sv
// Parse state and per-character update of the integer literal parser.
// Depends on ilp_pkg for radix, position, digit decode and result types.
module ilp_step #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilp_pkg::in_req_t      req_i,
  input  logic                  out_ready_i,
  output logic                  advance_o,
  output ilp_pkg::res_t         res_o,
  output logic [VALUE_BITS-1:0] value_o
);

  localparam int WideBits = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] accum_q, accum_d, accum_n;
  ilp_pkg::radix_e       radix_q, radix_d, radix_n;
  ilp_pkg::pos_e         pos_q, pos_d, pos_n;
  logic                  first_zero_q, first_zero_d, first_zero_n;
  logic                  seen_digit_q, seen_digit_d, seen_digit_n;
  logic                  prior_us_q, prior_us_d, prior_us_n;
  logic                  failed_q, failed_d, failed_n;

  logic [7:0]            c;
  logic [4:0]            digit;
  logic [WideBits-1:0]   acc_ext, product, sum;
  logic                  overflow;
  logic                  is_prefix;
  ilp_pkg::radix_e       prefix_radix;
  logic                  ok;

  assign c = req_i.item.char_code;

  // Consume a request; a final character needs room in the result register
  assign advance_o = req_i.valid && (!req_i.item.final_char || out_ready_i);

  // Scale the accumulator by the base with shifts, and one add for decimal
  assign acc_ext = {4'b0000, accum_q};
  always_comb begin
    unique case (radix_q)
      ilp_pkg::RADIX_DEC: product = (acc_ext << 3) + (acc_ext << 1);
      ilp_pkg::RADIX_HEX: product = acc_ext << 4;
      ilp_pkg::RADIX_OCT: product = acc_ext << 3;
      ilp_pkg::RADIX_BIN: product = acc_ext << 1;
      default:            product = acc_ext;
    endcase
  end

  assign digit    = ilp_pkg::digit_of(c);
  assign sum      = product + WideBits'(digit);
  assign overflow = |sum[WideBits-1:VALUE_BITS];

  // Detect a base prefix letter
  always_comb begin
    is_prefix    = 1'b1;
    prefix_radix = ilp_pkg::RADIX_DEC;
    priority if (c == ilp_pkg::CHAR_X_LO || c == ilp_pkg::CHAR_X_UP) begin
      prefix_radix = ilp_pkg::RADIX_HEX;
    end else if (c == ilp_pkg::CHAR_O_LO || c == ilp_pkg::CHAR_O_UP) begin
      prefix_radix = ilp_pkg::RADIX_OCT;
    end else if (c == ilp_pkg::CHAR_B_LO || c == ilp_pkg::CHAR_B_UP) begin
      prefix_radix = ilp_pkg::RADIX_BIN;
    end else begin
      is_prefix = 1'b0;
    end
  end

  // Advance the saturating character position
  always_comb begin
    unique case (pos_q)
      ilp_pkg::POS_FIRST:  pos_n = ilp_pkg::POS_SECOND;
      ilp_pkg::POS_SECOND: pos_n = ilp_pkg::POS_LATER;
      default:             pos_n = ilp_pkg::POS_LATER;
    endcase
  end

  // Apply one character to the parse state
  always_comb begin
    accum_n      = accum_q;
    radix_n      = radix_q;
    first_zero_n = first_zero_q;
    seen_digit_n = seen_digit_q;
    prior_us_n   = prior_us_q;
    failed_n     = failed_q;
    if (!failed_q) begin
      if (pos_q == ilp_pkg::POS_FIRST && c == ilp_pkg::CHAR_ZERO) begin
        first_zero_n = 1'b1;
      end
      if (pos_q == ilp_pkg::POS_SECOND && first_zero_q && is_prefix) begin
        radix_n      = prefix_radix;
        accum_n      = '0;
        seen_digit_n = 1'b0;
        prior_us_n   = 1'b0;
      end else if (c == ilp_pkg::CHAR_UNDERSCORE) begin
        if (!seen_digit_q || prior_us_q) begin
          failed_n = 1'b1;
        end else begin
          prior_us_n = 1'b1;
        end
      end else if (!ilp_pkg::digit_fits(digit, radix_q) || overflow) begin
        failed_n = 1'b1;
      end else begin
        accum_n      = sum[VALUE_BITS-1:0];
        seen_digit_n = 1'b1;
        prior_us_n   = 1'b0;
      end
    end
  end

  // Judge the literal from the updated state
  assign ok = !failed_n && seen_digit_n && !prior_us_n;

  always_comb begin
    res_o.fire     = advance_o && req_i.item.final_char;
    res_o.is_valid = ok;
    value_o        = ok ? accum_n : '0;
  end

  // Commit the update, or drop back to the start state after a final character
  always_comb begin
    accum_d      = accum_q;
    radix_d      = radix_q;
    pos_d        = pos_q;
    first_zero_d = first_zero_q;
    seen_digit_d = seen_digit_q;
    prior_us_d   = prior_us_q;
    failed_d     = failed_q;
    if (advance_o) begin
      if (req_i.item.final_char) begin
        accum_d      = '0;
        radix_d      = ilp_pkg::RADIX_DEC;
        pos_d        = ilp_pkg::POS_FIRST;
        first_zero_d = 1'b0;
        seen_digit_d = 1'b0;
        prior_us_d   = 1'b0;
        failed_d     = 1'b0;
      end else begin
        accum_d      = accum_n;
        radix_d      = radix_n;
        pos_d        = pos_n;
        first_zero_d = first_zero_n;
        seen_digit_d = seen_digit_n;
        prior_us_d   = prior_us_n;
        failed_d     = failed_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q      <= '0;
      radix_q      <= ilp_pkg::RADIX_DEC;
      pos_q        <= ilp_pkg::POS_FIRST;
      first_zero_q <= 1'b0;
      seen_digit_q <= 1'b0;
      prior_us_q   <= 1'b0;
      failed_q     <= 1'b0;
    end else begin
      accum_q      <= accum_d;
      radix_q      <= radix_d;
      pos_q        <= pos_d;
      first_zero_q <= first_zero_d;
      seen_digit_q <= seen_digit_d;
      prior_us_q   <= prior_us_d;
      failed_q     <= failed_d;
    end
  end

endmodule

// File: rtl/core/ilp_out_reg.sv
// Result register of the integer literal parser.
// Depends on ilp_pkg for the result type.
module ilp_out_reg #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilp_pkg::res_t         res_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_stall_i,
  output logic                  out_ready_o,
  output logic                  out_valid_o,
  output logic                  is_valid_o,
  output logic [VALUE_BITS-1:0] parsed_value_o
);

  logic                  valid_q, valid_d;
  logic                  is_valid_q, is_valid_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  // Room for a new request when empty or being taken this cycle
  assign out_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d    = valid_q;
    is_valid_d = is_valid_q;
    value_d    = value_q;
    if (res_i.fire) begin
      valid_d    = 1'b1;
      is_valid_d = res_i.is_valid;
      value_d    = value_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the next result
  always_ff @(posedge clk_i) begin
    is_valid_q <= is_valid_d;
    value_q    <= value_d;
  end

  assign out_valid_o    = valid_q;
  assign is_valid_o     = is_valid_q;
  assign parsed_value_o = value_q;

endmodule

// File: rtl/core/integer_literal_parser.sv
// Streaming parser for an unsigned integer literal with optional 0x/0o/0b prefix.
// A result shows on out_valid_o in the cycle after its final character is taken.
// One character per unstalled cycle; the accumulator update (shift-add by the base
// plus digit and overflow check) completes between the input and result registers.
// Reset: rst_ni clears all control and parse state; the parser starts a new literal.
// Uses ilp_pkg, ilp_in_reg, ilp_step and ilp_out_reg.
module integer_literal_parser #(
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  final_char_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_valid_o,
  output logic [VALUE_BITS-1:0] parsed_value_o
);

  ilp_pkg::in_req_t      req;
  ilp_pkg::res_t         res;
  logic [VALUE_BITS-1:0] value;
  logic                  advance;
  logic                  out_ready;

  // Register the incoming character
  ilp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .char_code_i  (char_code_i),
    .final_char_i (final_char_i),
    .advance_i    (advance),
    .in_stall_o   (in_stall_o),
    .req_o        (req)
  );

  // Update the parse state
  ilp_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .out_ready_i (out_ready),
    .advance_o   (advance),
    .res_o       (res),
    .value_o     (value)
  );

  // Register the result
  ilp_out_reg #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out_reg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_i          (res),
    .value_i        (value),
    .out_stall_i    (out_stall_i),
    .out_ready_o    (out_ready),
    .out_valid_o    (out_valid_o),
    .is_valid_o     (is_valid_o),
    .parsed_value_o (parsed_value_o)
  );

endmodule

// File: rtl/core/ilp_checker.sv
// Port-level assertions for the integer literal parser, bound to the top level.
// Depends on integer_literal_parser_macros.svh.
`include "integer_literal_parser_macros.svh"

module ilp_checker #(
  parameter int VALUE_BITS = 64
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            char_code_i,
  input logic                  final_char_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  is_valid_o,
  input logic [VALUE_BITS-1:0] parsed_value_o
);

  // A stalled request keeps its payload
  `ILP_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o,
    in_valid_i && $stable(char_code_i) && $stable(final_char_i),
    "stalled request changed")

  // A stalled result keeps its payload
  `ILP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(is_valid_o) && $stable(parsed_value_o),
    "stalled result changed")

  // A rejected literal reports a zero value
  `ILP_ASSERT_NOW(a_bad_zero, out_valid_o && !is_valid_o, parsed_value_o == '0,
    "invalid literal with nonzero value")

  // Input stalls only under result backpressure
  `ILP_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without output backpressure")

endmodule

bind integer_literal_parser ilp_checker #(.VALUE_BITS(VALUE_BITS)) u_ilp_checker (.*);
